/* rtl/core/bhc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_pkg: shared types and constants of the buzhash chunker
// Widths, action and register codes, reset values and the rotate helper.
// ----------------------------------------------------------------------------
package bhc_pkg;

    localparam int WINDOW_BYTES = 64;
    localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
    localparam int OUT_ROT      = WINDOW_BYTES % 32;

    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 32;
    localparam int LEN_W    = 25;
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW   = 8;

    localparam int ACT_W       = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EOS   = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

    localparam logic [LEN_W-1:0]  MIN_RESET  = 25'd65536;
    localparam logic [LEN_W-1:0]  MAX_RESET  = 25'd8388608;
    localparam logic [HASH_W-1:0] MASK_RESET = 32'd1048575;

    typedef struct packed {
        logic [LEN_W-1:0]  len_min;
        logic [LEN_W-1:0]  len_max;
        logic [HASH_W-1:0] mask;
    } t_cfg;

    // item held between the input register and the result register
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic              full;
    } t_stage;

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x,
                                               input int unsigned n);
        int unsigned k;
        k = n % HASH_W;
        if (k == 0) begin
            return x;
        end
        return (x << k) | (x >> (HASH_W - k));
    endfunction

endpackage

/* rtl/core/buzhash_content_defined_chunker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzhash_content_defined_chunker: content-defined chunker on a byte stream
// Rolling buzhash over a sliding window with min/max chunk size and mask.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a result is held on the master side. At the
// transaction on the slave side the item lands in the input register and both
// substitution table reads are issued (two copies of the 256-word table, one
// for the incoming byte and one for the byte leaving the window, each with
// registered read data). When the output register is free or being emptied,
// the rotate-XOR hash update and boundary compare land in it, so a result is
// offered on the master side after the input register and the output register.
// The hash and length feedback sits entirely in that second stage, so
// back-to-back data bytes run at full rate; the output register lets a new
// item enter while a result waits on the master side. Table words must be
// written before any byte that reads them. Item kind travels in tuser: data
// byte, table write, end of stream. Each data byte gives one result; an end
// of stream gives a flush result only when the open chunk is non-empty;
// table writes and the unused code give none. tlast marks a chunk end. Size
// and mask registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module buzhash_content_defined_chunker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] data_byte, [15:8] table_index, [47:16] table_word
    input  logic [bhc_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [1:0] action
    input  logic [bhc_pkg::ACT_W-1:0]           i_s_tuser,
    // master side
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [32:8] chunk_length, [64:33] rolling_hash, [71:65] zero
    output logic [bhc_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [0] has_byte
    output logic [0:0]                          o_m_tuser,
    // chunk_end
    output logic                                o_m_tlast,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bhc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bhc_pkg::HASH_W-1:0]          i_cfg_data
);
    import bhc_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input stage register
    logic   r_s1_valid, n_s1_valid;
    t_stage r_s1;

    logic              w_accept;
    logic              w_push, w_clear, w_twrite;
    logic              w_advance;
    logic [BYTE_W-1:0] w_byte;
    logic [TBL_AW-1:0] w_tindex;
    logic [HASH_W-1:0] w_tword;
    logic [BYTE_W-1:0] w_old_byte;
    logic              w_full;
    logic [HASH_W-1:0] w_new_word, w_old_word;

    logic              w_out_has_byte;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_out_end;
    logic [LEN_W-1:0]  w_out_len;
    logic [HASH_W-1:0] w_out_hash;

    assign w_byte   = i_s_tdata[7:0];
    assign w_tindex = i_s_tdata[15:8];
    assign w_tword  = i_s_tdata[47:16];

    // accept when the input stage is empty or hands its item on this cycle
    assign o_s_tready = !r_s1_valid || w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_push     = w_accept && (i_s_tuser == ACT_DATA);
    assign w_clear    = w_accept && (i_s_tuser == ACT_EOS);
    assign w_twrite   = w_accept && (i_s_tuser == ACT_WRITE);

    // configuration: always ready, drop writes to unknown indexes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_min <= MIN_RESET;
            r_cfg.len_max <= MAX_RESET;
            r_cfg.mask    <= MASK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN:  r_cfg.len_min <= i_cfg_data[LEN_W-1:0];
                CFG_MAX:  r_cfg.len_max <= i_cfg_data[LEN_W-1:0];
                CFG_MASK: r_cfg.mask    <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // only data bytes and end-of-stream items travel on; table writes finish
    // in the RAMs at their transaction
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = w_push || w_clear;
        end else if (w_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // window state is sampled at the transaction, before the new byte shifts in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.action    <= i_s_tuser;
            r_s1.data_byte <= w_byte;
            r_s1.full      <= w_full;
        end
    end

    bhc_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_clear    (w_clear),
        .i_byte     (w_byte),
        .o_old_byte (w_old_byte),
        .o_full     (w_full)
    );

    // read data holds while the input stage stalls, since reads fire only
    // on a data transaction
    bhc_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_new (
        .i_clk   (i_clk),
        .i_we    (w_twrite),
        .i_waddr (w_tindex),
        .i_wdata (w_tword),
        .i_re    (w_push),
        .i_raddr (w_byte),
        .o_rdata (w_new_word)
    );

    bhc_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_old (
        .i_clk   (i_clk),
        .i_we    (w_twrite),
        .i_waddr (w_tindex),
        .i_wdata (w_tword),
        .i_re    (w_push),
        .i_raddr (w_old_byte),
        .o_rdata (w_old_word)
    );

    bhc_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s1_valid  (r_s1_valid),
        .i_s1        (r_s1),
        .i_new_word  (w_new_word),
        .i_old_word  (w_old_word),
        .i_m_ready   (i_m_tready),
        .o_advance   (w_advance),
        .o_valid     (o_m_tvalid),
        .o_has_byte  (w_out_has_byte),
        .o_out_byte  (w_out_byte),
        .o_chunk_end (w_out_end),
        .o_chunk_len (w_out_len),
        .o_hash      (w_out_hash)
    );

    assign o_m_tdata = {7'd0, w_out_hash, w_out_len, w_out_byte};
    assign o_m_tuser = w_out_has_byte;
    assign o_m_tlast = w_out_end;

endmodule

/* rtl/core/bhc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module bhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bhc_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_window: sliding byte window
// Shift line of the last window bytes plus a fill counter that says when the
// oldest tap holds a real outgoing byte.
// ----------------------------------------------------------------------------
module bhc_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_clear,
    input  logic [bhc_pkg::BYTE_W-1:0] i_byte,
    output logic [bhc_pkg::BYTE_W-1:0] o_old_byte,
    output logic                 o_full
);
    import bhc_pkg::*;

    logic [BYTE_W-1:0] r_taps [WINDOW_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    // taps are only read once the fill count says they were written
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_taps[0] <= i_byte;
            for (int i = 1; i < WINDOW_BYTES; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    assign o_full     = (r_fill == FILL_W'(WINDOW_BYTES));
    assign o_old_byte = r_taps[WINDOW_BYTES-1];

    always_comb begin
        n_fill = r_fill;
        if (i_clear) begin
            n_fill = '0;
        end else if (i_push && !o_full) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

/* rtl/core/bhc_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhc_hash: rolling hash update, chunk decision and result register
// Holds the hash and chunk length; builds one result per data byte or flush.
// ----------------------------------------------------------------------------
module bhc_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bhc_pkg::t_cfg               i_cfg,
    input  logic                        i_s1_valid,
    input  bhc_pkg::t_stage             i_s1,
    input  logic [bhc_pkg::HASH_W-1:0]  i_new_word,
    input  logic [bhc_pkg::HASH_W-1:0]  i_old_word,
    input  logic                        i_m_ready,
    output logic                        o_advance,
    output logic                        o_valid,
    output logic                        o_has_byte,
    output logic [bhc_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_chunk_end,
    output logic [bhc_pkg::LEN_W-1:0]   o_chunk_len,
    output logic [bhc_pkg::HASH_W-1:0]  o_hash
);
    import bhc_pkg::*;

    logic [HASH_W-1:0] r_hash, n_hash;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_valid, n_valid;
    logic              r_has_byte, n_has_byte;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_end, n_end;
    logic [LEN_W-1:0]  r_olen, n_olen;
    logic [HASH_W-1:0] r_ohash, n_ohash;

    logic [HASH_W-1:0] w_hash;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_eff_min;
    logic              w_end;

    assign o_advance = i_s1_valid && (!r_valid || i_m_ready);

    assign w_hash = rotl(r_hash, 1) ^ i_new_word
                  ^ (i_s1.full ? rotl(i_old_word, OUT_ROT) : '0);
    assign w_len     = r_len + LEN_W'(1);
    assign w_eff_min = (i_cfg.len_min < i_cfg.len_max) ? i_cfg.len_min
                                                       : i_cfg.len_max;
    assign w_end = (w_len >= w_eff_min)
                && (((w_hash & i_cfg.mask) == '0) || (w_len >= i_cfg.len_max));

    always_comb begin
        n_hash     = r_hash;
        n_len      = r_len;
        n_valid    = r_valid && !i_m_ready;
        n_has_byte = r_has_byte;
        n_out_byte = r_out_byte;
        n_end      = r_end;
        n_olen     = r_olen;
        n_ohash    = r_ohash;
        if (o_advance) begin
            case (i_s1.action)
                ACT_DATA: begin
                    n_hash     = w_hash;
                    n_len      = w_end ? '0 : w_len;
                    n_valid    = 1'b1;
                    n_has_byte = 1'b1;
                    n_out_byte = i_s1.data_byte;
                    n_end      = w_end;
                    n_olen     = w_len;
                    n_ohash    = w_hash;
                end
                ACT_EOS: begin
                    // flush only a non-empty chunk, then clear the stream
                    n_hash     = '0;
                    n_len      = '0;
                    n_valid    = (r_len != '0);
                    n_has_byte = 1'b0;
                    n_out_byte = '0;
                    n_end      = 1'b1;
                    n_olen     = r_len;
                    n_ohash    = r_hash;
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_hash  <= n_hash;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_has_byte <= n_has_byte;
        r_out_byte <= n_out_byte;
        r_end      <= n_end;
        r_olen     <= n_olen;
        r_ohash    <= n_ohash;
    end

    assign o_valid     = r_valid;
    assign o_has_byte  = r_has_byte;
    assign o_out_byte  = r_out_byte;
    assign o_chunk_end = r_end;
    assign o_chunk_len = r_olen;
    assign o_hash      = r_ohash;

endmodule

/* verif/tb_buzhash_content_defined_chunker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzhash_content_defined_chunker: self-checking bench of the chunker
// Loads the substitution table, runs a table of directed items at the reset
// sizes, then random phases, each under its own size and mask setting. A
// behavioral predictor of the rolling hash and chunk length checks each
// result field by field; a typed row is held to its own fixed mark instead.
// ----------------------------------------------------------------------------
module tb_buzhash_content_defined_chunker;
    import bhc_pkg::*;

    // The package names the three live action codes; the fourth is ignored.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int SETTLE_PAD   = 6;     // covers the two-stage pipe
    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
        logic              chunk_end;
        logic [LEN_W-1:0]  chunk_length;
        logic [HASH_W-1:0] rolling_hash;
    } t_mark;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic [TBL_AW-1:0] tbl_idx;
        logic [HASH_W-1:0] tbl_word;
        logic              typed;    // use the mark below instead of the predictor
        t_mark             mark;
    } t_row;

    localparam t_mark NO_MARK = '0;

    // Directed rows: right after the table load, reset sizes still in place.
    localparam int N_ROWS = 20;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // end of stream on an empty chunk after reset: no flush
        '{ACT_EOS,    8'h00, 8'h00, 32'h0000_0000, 1'b0, NO_MARK},
        // unused code: dropped
        '{ACT_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_MARK},
        '{ACT_WRITE,  8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_MARK},
        '{ACT_WRITE,  8'h00, 8'h00, 32'h0000_0001, 1'b0, NO_MARK},
        // first byte from a clear hash: hash is the table word itself
        '{ACT_DATA,   8'h00, 8'h00, 32'h0, 1'b1,
          '{1'b1, 8'h00, 1'b0, 25'd1, 32'h0000_0001}},
        '{ACT_DATA,   8'hFF, 8'h00, 32'h0, 1'b1,
          '{1'b1, 8'hFF, 1'b0, 25'd2, 32'hFFFF_FFFD}},
        // flush of the open two-byte chunk
        '{ACT_EOS,    8'h00, 8'h00, 32'h0, 1'b1,
          '{1'b0, 8'h00, 1'b1, 25'd2, 32'hFFFF_FFFD}},
        '{ACT_EOS,    8'h00, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_WRITE,  8'h00, 8'h80, 32'hA5A5_A5A5, 1'b0, NO_MARK},
        '{ACT_WRITE,  8'h00, 8'h7F, 32'h5A5A_5A5A, 1'b0, NO_MARK},
        '{ACT_DATA,   8'h80, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_DATA,   8'h7F, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_DATA,   8'h01, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_UNUSED, 8'h55, 8'h33, 32'h1234_5678, 1'b0, NO_MARK},
        '{ACT_DATA,   8'hFE, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_DATA,   8'h00, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_DATA,   8'hFF, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_EOS,    8'h00, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_DATA,   8'hAA, 8'h00, 32'h0, 1'b0, NO_MARK},
        '{ACT_EOS,    8'h00, 8'h00, 32'h0, 1'b0, NO_MARK}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata;
    logic [ACT_W-1:0]        i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic [0:0]              o_m_tuser;
    logic                    o_m_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [HASH_W-1:0]       i_cfg_data;

    buzhash_content_defined_chunker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Chunker predictor: its own copy of table, window, hash, length, sizes
    // ------------------------------------------------------------------------
    logic [HASH_W-1:0] subst_words [TBL_DEPTH];
    logic [BYTE_W-1:0] win_bytes [WINDOW_BYTES];
    int unsigned       win_head;
    int unsigned       win_count;
    logic [HASH_W-1:0] hash_acc;
    logic [LEN_W-1:0]  open_len;
    logic [LEN_W-1:0]  min_len_cfg;
    logic [LEN_W-1:0]  max_len_cfg;
    logic [HASH_W-1:0] cut_mask_cfg;

    t_mark             marks_due [$];   // chunk marks still owed by the block
    int unsigned       fail_count;

    logic              burst_mode;      // both sides stop idling
    logic              hold_req;        // ask the receiver for a long hold-off
    int unsigned       hold_left;
    int unsigned       quiet_cycles;

    function automatic logic [HASH_W-1:0] rot_left(input logic [HASH_W-1:0] x,
                                                   input int unsigned n);
        int unsigned k;
        k = n % HASH_W;
        // a zero shift collapses to x | x
        return (x << k) | (x >> ((HASH_W - k) % HASH_W));
    endfunction

    function automatic void clear_stream();
        hash_acc  = '0;
        win_head  = 0;
        win_count = 0;
        open_len  = '0;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            win_bytes[i] = '0;
        end
    endfunction

    // Advance the predictor by one accepted item; return 1 if it owes a mark.
    function automatic bit chunk_step(input logic [ACT_W-1:0] act,
                                      input logic [BYTE_W-1:0] b,
                                      input logic [TBL_AW-1:0] idx,
                                      input logic [HASH_W-1:0] word,
                                      output t_mark m);
        logic [BYTE_W-1:0] leaving;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  floor_len;
        logic              cut;
        m = '0;
        case (act)
            ACT_DATA: begin
                leaving = win_bytes[win_head];
                win_bytes[win_head] = b;
                win_head = (win_head + 1) % WINDOW_BYTES;
                hash_acc = rot_left(hash_acc, 1) ^ subst_words[b];
                // the leaving byte only counts once the window is full
                if (win_count < WINDOW_BYTES) begin
                    win_count++;
                end else begin
                    hash_acc ^= rot_left(subst_words[leaving], WINDOW_BYTES % 32);
                end
                len       = open_len + 1'b1;
                floor_len = (min_len_cfg < max_len_cfg) ? min_len_cfg : max_len_cfg;
                cut = (len >= floor_len)
                      && (((hash_acc & cut_mask_cfg) == '0) || (len >= max_len_cfg));
                m = '{1'b1, b, cut, len, hash_acc};
                open_len = cut ? '0 : len;
                return 1'b1;
            end
            ACT_WRITE: begin
                subst_words[idx] = word;
                return 1'b0;
            end
            ACT_EOS: begin
                bit flush;
                flush = (open_len != '0);
                m = '{1'b0, 8'h00, 1'b1, open_len, hash_acc};
                clear_stream();
                return flush;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side: drive at the falling edge, take the transaction at the
    // rising edge. Leave tvalid high on return so back-to-back items never
    // lower and raise it in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [BYTE_W-1:0] b,
                             input logic [TBL_AW-1:0] idx,
                             input logic [HASH_W-1:0] word,
                             input logic typed,
                             input t_mark typed_mark);
        t_mark m;
        bit    owed;
        while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {word, idx, b};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        owed = chunk_step(act, b, idx, word, m);
        if (typed) begin
            marks_due.push_back(typed_mark);
        end else if (owed) begin
            marks_due.push_back(m);
        end
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(99);
        // mostly bytes with random content, some stream ends and table
        // rewrites, and a little noise on the unused code
        if (pick < 82) begin
            act = ACT_DATA;
        end else if (pick < 90) begin
            act = ACT_EOS;
        end else if (pick < 96) begin
            act = ACT_WRITE;
        end else begin
            act = ACT_UNUSED;
        end
        send_item(act, BYTE_W'($urandom), TBL_AW'($urandom), $urandom, 1'b0, NO_MARK);
    endtask

    // Hold the sender until every owed mark is back, then let the pipe settle
    // in case the last item (a table write or a quiet stream end) is in flight.
    task automatic drain_marks();
        i_s_tvalid <= 1'b0;
        while (marks_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_PAD) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [HASH_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_MIN:  min_len_cfg  = val[LEN_W-1:0];
            CFG_MAX:  max_len_cfg  = val[LEN_W-1:0];
            CFG_MASK: cut_mask_cfg = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // One random phase under one size setting; entered with the block idle.
    task automatic run_phase(input logic [HASH_W-1:0] min_len,
                             input logic [HASH_W-1:0] max_len,
                             input logic [HASH_W-1:0] mask,
                             input int unsigned n_items,
                             input bit burst,
                             input bit hold);
        cfg_write(CFG_MIN, min_len);
        cfg_write(CFG_MAX, max_len);
        cfg_write(CFG_MASK, mask);
        i_cfg_valid <= 1'b0;
        burst_mode = burst;
        hold_req   = hold;
        repeat (n_items) send_random_item();
        burst_mode = 1'b0;
        drain_marks();
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random tready, with an occasional long hold-off that it
    // counts itself while the sender keeps offering items.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name,
                               input logic [HASH_W-1:0] want,
                               input logic [HASH_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction with the oldest owed mark.
    always @(posedge i_clk) begin
        t_mark want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (marks_due.size() == 0) begin
                $error("unexpected result: has_byte %0d, chunk_length %0d",
                       o_m_tuser[0], o_m_tdata[8 +: LEN_W]);
                fail_count++;
            end else begin
                want = marks_due.pop_front();
                check_field("has_byte", HASH_W'(want.has_byte), HASH_W'(o_m_tuser[0]));
                check_field("out_byte", HASH_W'(want.out_byte),
                            HASH_W'(o_m_tdata[0 +: BYTE_W]));
                check_field("chunk_end", HASH_W'(want.chunk_end), HASH_W'(o_m_tlast));
                check_field("chunk_length", HASH_W'(want.chunk_length),
                            HASH_W'(o_m_tdata[8 +: LEN_W]));
                check_field("rolling_hash", want.rolling_hash,
                            o_m_tdata[8 + LEN_W +: HASH_W]);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on any channel too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[buzhash_content_defined_chunker] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = ACT_DATA;
        i_m_tready   = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_MIN;
        i_cfg_data   = '0;
        burst_mode   = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        fail_count   = 0;
        min_len_cfg  = MIN_RESET;
        max_len_cfg  = MAX_RESET;
        cut_mask_cfg = MASK_RESET;
        clear_stream();
        for (int i = 0; i < TBL_DEPTH; i++) begin
            subst_words[i] = '0;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill every table entry before any byte can read one.
        for (int i = 0; i < TBL_DEPTH; i++) begin
            send_item(ACT_WRITE, BYTE_W'($urandom), i[TBL_AW-1:0], $urandom,
                      1'b0, NO_MARK);
        end

        foreach (DIRECTED_ROWS[r]) begin
            send_item(DIRECTED_ROWS[r].action, DIRECTED_ROWS[r].data_byte,
                      DIRECTED_ROWS[r].tbl_idx, DIRECTED_ROWS[r].tbl_word,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].mark);
        end
        drain_marks();

        // smallest sizes: every byte closes a chunk
        run_phase(32'd1, 32'd1, $urandom, 70, 1'b0, 1'b0);
        // zero sizes
        run_phase(32'd0, 32'd0, $urandom, 55, 1'b0, 1'b0);
        // frequent hash cuts, with the long receiver hold-off
        run_phase(32'd4, 32'd40, 32'h0000_0007, 85, 1'b1, 1'b1);
        // minimum above maximum
        run_phase(32'd24, 32'd9, 32'h0000_0003, 70, 1'b0, 1'b0);
        // largest sizes, zero mask
        run_phase(32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 55, 1'b0, 1'b0);
        // hash-driven cuts only
        run_phase(32'd2, 32'h0100_0000, 32'h0000_000F, 85, 1'b0, 1'b0);
        // full mask: only the maximum cuts; no idling on either side
        run_phase(32'd1, 32'd300, 32'hFFFF_FFFF, 85, 1'b1, 1'b0);
        // zero mask: every byte from the minimum on cuts
        run_phase(32'd3, 32'd60, 32'h0000_0000, 55, 1'b0, 1'b0);
        // random sizes and a random narrow mask
        run_phase($urandom_range(64, 1), $urandom_range(128, 1),
                  $urandom & ((32'h1 << $urandom_range(6)) - 1), 70, 1'b0, 1'b0);

        repeat (SETTLE_PAD) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[buzhash_content_defined_chunker] OK");
        end else begin
            $display("[buzhash_content_defined_chunker] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bhc_pkg.sv
rtl/core/bhc_ram.sv
rtl/core/bhc_window.sv
rtl/core/bhc_hash.sv
rtl/core/buzhash_content_defined_chunker.sv
verif/tb_buzhash_content_defined_chunker.sv
